/* rtl/hdot_pkg.sv */
// shared constants, codes and types of the hierarchical depth occlusion test
package hdot_pkg;

   localparam int BUF_W   = 256;
   localparam int BUF_H   = 128;
   localparam int TILE_W  = 8;
   localparam int TILE_H  = 8;
   localparam int TILES_X = BUF_W / TILE_W;
   localparam int TILES_Y = BUF_H / TILE_H;
   localparam int TILES   = TILES_X * TILES_Y;
   localparam int PIX     = BUF_W * BUF_H;

   localparam int PIX_AW = (PIX > 1) ? $clog2(PIX) : 1;
   localparam int TAW    = (TILES > 1) ? $clog2(TILES) : 1;
   localparam int TXW    = (TILES_X > 1) ? $clog2(TILES_X) : 1;
   localparam int TYW    = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;
   localparam int LXW    = (TILE_W > 1) ? $clog2(TILE_W) : 1;
   localparam int LYW    = (TILE_H > 1) ? $clog2(TILE_H) : 1;

   localparam logic [15:0] DEPTH_EMPTY = 16'hFFFF;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_BUILD = 2'd2;
   localparam logic [1:0] ACT_QUERY = 2'd3;

   typedef struct packed {
      logic signed [12:0] rect_y1;
      logic signed [12:0] rect_y0;
      logic signed [12:0] rect_x1;
      logic signed [12:0] rect_x0;
      logic [15:0]        depth_value;
      logic [6:0]         pixel_y;
      logic [7:0]         pixel_x;
      logic [1:0]         action;
   } item_type;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic pix_rd;
      logic pix_wr;
      logic bld_rd;
      logic bld_acc;
      logic q_setup;
      logic q_rd;
      logic q_chk;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] act;
      logic       clr_last;
      logic       bld_last;
      logic       q_skip;
      logic       q_stop;
   } status_type;

endpackage

/* rtl/hdot_ctrl.sv */
// controller state machine of the hierarchical depth occlusion test
module hdot_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  hdot_pkg::status_type sts,
   output hdot_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_CLR     = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DISP    = 4'd2;
   localparam logic [3:0] S_WR_RD   = 4'd3;
   localparam logic [3:0] S_WR_WB   = 4'd4;
   localparam logic [3:0] S_BLD_RD  = 4'd5;
   localparam logic [3:0] S_BLD_ACC = 4'd6;
   localparam logic [3:0] S_Q_SETUP = 4'd7;
   localparam logic [3:0] S_Q_RD    = 4'd8;
   localparam logic [3:0] S_Q_CHK   = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = pend_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (sts.act)
               hdot_pkg::ACT_CLEAR: begin
                  pend_in  = 1'b1;
                  state_in = S_CLR;
               end
               hdot_pkg::ACT_WRITE: state_in = S_WR_RD;
               hdot_pkg::ACT_BUILD: state_in = S_BLD_RD;
               default:             state_in = S_Q_SETUP;
            endcase
         end
         S_WR_RD: begin
            cmd.pix_rd = 1'b1;
            state_in   = S_WR_WB;
         end
         S_WR_WB: begin
            cmd.pix_wr = 1'b1;
            state_in   = S_DONE;
         end
         S_BLD_RD: begin
            cmd.bld_rd = 1'b1;
            state_in   = S_BLD_ACC;
         end
         S_BLD_ACC: begin
            cmd.bld_acc = 1'b1;
            state_in    = sts.bld_last ? S_DONE : S_BLD_RD;
         end
         S_Q_SETUP: begin
            cmd.q_setup = 1'b1;
            state_in    = sts.q_skip ? S_DONE : S_Q_RD;
         end
         S_Q_RD: begin
            cmd.q_rd = 1'b1;
            state_in = S_Q_CHK;
         end
         S_Q_CHK: begin
            cmd.q_chk = 1'b1;
            state_in  = sts.q_stop ? S_DONE : S_Q_RD;
         end
         S_DONE: begin
            // result register must be free before the new item lands in it
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= (state_in == S_CLR) ? pend_in : 1'b0;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/hdot_datapath.sv */
// depth buffer, tile maxima table, counters and compares
module hdot_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  hdot_pkg::item_type   item,
   input  hdot_pkg::cmd_type    cmd,
   output hdot_pkg::status_type sts,
   output logic                 out_hidden,
   output logic                 out_active
);

   logic [15:0] depth_mem [hdot_pkg::PIX];
   logic [15:0] tile_mem  [hdot_pkg::TILES];

   hdot_pkg::item_type item_ff;
   logic [hdot_pkg::PIX_AW-1:0] clr_ff;
   logic [hdot_pkg::LXW-1:0]    x_ff;
   logic [hdot_pkg::LYW-1:0]    y_ff;
   logic [hdot_pkg::TXW-1:0]    tx_ff, qtx0_ff, qtx1_ff;
   logic [hdot_pkg::TYW-1:0]    ty_ff, qty1_ff;
   logic [15:0]                 max_ff, rd_ff, trd_ff;
   logic                        active_ff, hidden_ff, out_hidden_ff, out_active_ff;

   logic                        we;
   logic [hdot_pkg::PIX_AW-1:0] wa, ra, wr_addr, bld_addr;
   logic [15:0]                 wd, m_next;
   logic [hdot_pkg::TAW-1:0]    bld_taddr, q_taddr;
   logic                        in_range, x_last, y_last, tx_last, ty_last, tile_last;
   logic                        q_fail, q_last;
   int                          x0, x1, y0, y1, tx0_i, tx1_i, ty0_i, ty1_i;

   assign wr_addr  = hdot_pkg::PIX_AW'(int'(item_ff.pixel_y) * hdot_pkg::BUF_W
                                     + int'(item_ff.pixel_x));
   assign in_range = (int'(item_ff.pixel_x) < hdot_pkg::BUF_W)
                  && (int'(item_ff.pixel_y) < hdot_pkg::BUF_H);
   assign bld_addr = hdot_pkg::PIX_AW'(
      (int'(ty_ff) * hdot_pkg::TILE_H + int'(y_ff)) * hdot_pkg::BUF_W
      + int'(tx_ff) * hdot_pkg::TILE_W + int'(x_ff));
   assign bld_taddr = hdot_pkg::TAW'(int'(ty_ff) * hdot_pkg::TILES_X + int'(tx_ff));
   assign q_taddr   = bld_taddr;

   assign x_last    = (x_ff == hdot_pkg::LXW'(hdot_pkg::TILE_W - 1));
   assign y_last    = (y_ff == hdot_pkg::LYW'(hdot_pkg::TILE_H - 1));
   assign tx_last   = (tx_ff == hdot_pkg::TXW'(hdot_pkg::TILES_X - 1));
   assign ty_last   = (ty_ff == hdot_pkg::TYW'(hdot_pkg::TILES_Y - 1));
   assign tile_last = x_last && y_last;
   assign m_next    = (rd_ff > max_ff) ? rd_ff : max_ff;

   // memory port selection
   always_comb begin
      we = 1'b0;
      wa = clr_ff;
      wd = hdot_pkg::DEPTH_EMPTY;
      if (cmd.clr_step) begin
         we = 1'b1;
      end else if (cmd.pix_wr && in_range && (item_ff.depth_value < rd_ff)) begin
         we = 1'b1;
         wa = wr_addr;
         wd = item_ff.depth_value;
      end
      ra = cmd.bld_rd ? bld_addr : wr_addr;
   end

   // query rectangle to tile range
   always_comb begin
      x0 = int'(item_ff.rect_x0);
      x1 = int'(item_ff.rect_x1);
      y0 = int'(item_ff.rect_y0);
      y1 = int'(item_ff.rect_y1);
      tx0_i = (x0 < 0) ? 0 : x0 / hdot_pkg::TILE_W;
      ty0_i = (y0 < 0) ? 0 : y0 / hdot_pkg::TILE_H;
      tx1_i = (x1 > 0) ? (x1 - 1) / hdot_pkg::TILE_W : 0;
      ty1_i = (y1 > 0) ? (y1 - 1) / hdot_pkg::TILE_H : 0;
      if (tx1_i >= hdot_pkg::TILES_X) tx1_i = hdot_pkg::TILES_X - 1;
      if (ty1_i >= hdot_pkg::TILES_Y) ty1_i = hdot_pkg::TILES_Y - 1;
   end

   assign q_fail = (trd_ff == hdot_pkg::DEPTH_EMPTY) || (item_ff.depth_value < trd_ff);
   assign q_last = (tx_ff == qtx1_ff) && (ty_ff == qty1_ff);

   assign sts.act      = item_ff.action;
   assign sts.clr_last = (clr_ff == hdot_pkg::PIX_AW'(hdot_pkg::PIX - 1));
   assign sts.bld_last = tile_last && tx_last && ty_last;
   assign sts.q_skip   = !active_ff || (x1 <= 0) || (y1 <= 0)
                      || (x0 >= hdot_pkg::BUF_W) || (y0 >= hdot_pkg::BUF_H)
                      || (x0 >= x1) || (y0 >= y1) || (tx0_i > tx1_i) || (ty0_i > ty1_i);
   assign sts.q_stop   = q_fail || q_last;

   assign out_hidden = out_hidden_ff;
   assign out_active = out_active_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         depth_mem[wa] <= wd;
      end
      if (cmd.pix_rd || cmd.bld_rd) begin
         rd_ff <= depth_mem[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bld_acc && tile_last) begin
         tile_mem[bld_taddr] <= m_next;
      end
      if (cmd.q_rd) begin
         trd_ff <= tile_mem[q_taddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= item;
      end
      if (cmd.q_setup) begin
         qtx0_ff <= hdot_pkg::TXW'(tx0_i);
         qtx1_ff <= hdot_pkg::TXW'(tx1_i);
         qty1_ff <= hdot_pkg::TYW'(ty1_i);
      end
      if (cmd.finish) begin
         out_hidden_ff <= hidden_ff;
         out_active_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         tx_ff     <= '0;
         ty_ff     <= '0;
         max_ff    <= '0;
         active_ff <= 1'b0;
         hidden_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            clr_ff    <= '0;
            x_ff      <= '0;
            y_ff      <= '0;
            tx_ff     <= '0;
            ty_ff     <= '0;
            max_ff    <= '0;
            hidden_ff <= 1'b0;
            if (item.action == hdot_pkg::ACT_CLEAR || item.action == hdot_pkg::ACT_BUILD) begin
               active_ff <= 1'b0;
            end
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.bld_acc) begin
            max_ff <= tile_last ? 16'd0 : m_next;
            if (tile_last && (m_next != hdot_pkg::DEPTH_EMPTY)) begin
               active_ff <= 1'b1;
            end
            // walk pixel column, pixel row, tile column, tile row
            x_ff <= x_last ? '0 : x_ff + 1'b1;
            if (x_last) begin
               y_ff <= y_last ? '0 : y_ff + 1'b1;
               if (y_last) begin
                  tx_ff <= tx_last ? '0 : tx_ff + 1'b1;
                  if (tx_last) begin
                     ty_ff <= ty_last ? '0 : ty_ff + 1'b1;
                  end
               end
            end
         end
         if (cmd.q_setup) begin
            tx_ff <= hdot_pkg::TXW'(tx0_i);
            ty_ff <= hdot_pkg::TYW'(ty0_i);
         end
         if (cmd.q_chk && !q_fail) begin
            if (q_last) begin
               hidden_ff <= 1'b1;
            end else if (tx_ff == qtx1_ff) begin
               tx_ff <= qtx0_ff;
               ty_ff <= ty_ff + 1'b1;
            end else begin
               tx_ff <= tx_ff + 1'b1;
            end
         end
      end
   end

endmodule

/* rtl/hierarchical_depth_occlusion_test_top.sv */
// top level of the hierarchical depth occlusion test
//
//  channel   ports         payload
//  request   req_t*        tdata: action, pixel_x, pixel_y, depth_value, rect x0 x1 y0 y1
//  response  rsp_t*        tdata: hidden, occluders_active
//
// clear: every pixel, one per cycle through the depth memory write port
// write: accept, dispatch, read, merge, finish; build: each pixel is read, then merged
// into its tile maximum; query: a read and a check of each tile visited through the tile
// table read port, none when the rectangle misses or the buffer is inactive
// after reset all BUF_W*BUF_H pixels are cleared before the first item is taken
// one item at a time; the next item is taken while the previous result waits in rsp
module hierarchical_depth_occlusion_test_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0], pixel_x[9:2], pixel_y[16:10], depth_value[32:17],
   // rect_x0[45:33], rect_x1[58:46], rect_y0[71:59], rect_y1[84:72]
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // hidden[0], occluders_active[1]
   output logic [7:0]  rsp_tdata
);

   hdot_pkg::cmd_type    cmd;
   hdot_pkg::status_type sts;
   hdot_pkg::item_type   item;
   logic                 out_hidden, out_active;

   assign item = hdot_pkg::item_type'(req_tdata[84:0]);
   assign rsp_tdata = {6'd0, out_active, out_hidden};

   hdot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hdot_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .cmd        (cmd),
      .sts        (sts),
      .out_hidden (out_hidden),
      .out_active (out_active)
   );

endmodule

/* verif/testbench.sv */
// self-checking testbench of the hierarchical depth occlusion test
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic hidden;
      logic active;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;

   hierarchical_depth_occlusion_test_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // model of the occluder buffer
   logic [15:0] pixel_depth [hdot_pkg::PIX];
   logic [15:0] tile_peak [hdot_pkg::TILES];
   logic        buffer_active;

   hdot_pkg::item_type pending_items [$];
   int                 pending_mode [$];
   answer_type         expected_answers [$];
   hdot_pkg::item_type held_item;
   int         stall_mode;
   int         error_count;
   int         answer_count;
   int         hidden_count;
   int         query_count;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic occlusion_answer(hdot_pkg::item_type it);
      int x0, x1, y0, y1, tx0, tx1, ty0, ty1;
      logic [15:0] m;
      x0 = $signed(it.rect_x0);
      x1 = $signed(it.rect_x1);
      y0 = $signed(it.rect_y0);
      y1 = $signed(it.rect_y1);
      if (!buffer_active) return 1'b0;
      if (x1 <= 0 || y1 <= 0 || x0 >= hdot_pkg::BUF_W || y0 >= hdot_pkg::BUF_H) return 1'b0;
      if (x0 >= x1 || y0 >= y1) return 1'b0;
      tx0 = x0 < 0 ? 0 : x0 / hdot_pkg::TILE_W;
      ty0 = y0 < 0 ? 0 : y0 / hdot_pkg::TILE_H;
      tx1 = (x1 - 1) / hdot_pkg::TILE_W;
      ty1 = (y1 - 1) / hdot_pkg::TILE_H;
      if (tx1 >= hdot_pkg::TILES_X) tx1 = hdot_pkg::TILES_X - 1;
      if (ty1 >= hdot_pkg::TILES_Y) ty1 = hdot_pkg::TILES_Y - 1;
      if (tx0 > tx1 || ty0 > ty1) return 1'b0;
      for (int ty = ty0; ty <= ty1; ty++) begin
         for (int tx = tx0; tx <= tx1; tx++) begin
            m = tile_peak[ty * hdot_pkg::TILES_X + tx];
            if (m == hdot_pkg::DEPTH_EMPTY || it.depth_value < m) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic apply_item(hdot_pkg::item_type it);
      answer_type a;
      logic [15:0] m;
      int addr;
      a.hidden = 1'b0;
      case (it.action)
         hdot_pkg::ACT_CLEAR: begin
            foreach (pixel_depth[i]) pixel_depth[i] = hdot_pkg::DEPTH_EMPTY;
            buffer_active = 1'b0;
         end
         hdot_pkg::ACT_WRITE: begin
            addr = int'(it.pixel_y) * hdot_pkg::BUF_W + int'(it.pixel_x);
            if (it.pixel_x < hdot_pkg::BUF_W && it.pixel_y < hdot_pkg::BUF_H
                && it.depth_value < pixel_depth[addr])
               pixel_depth[addr] = it.depth_value;
         end
         hdot_pkg::ACT_BUILD: begin
            buffer_active = 1'b0;
            for (int t = 0; t < hdot_pkg::TILES; t++) begin
               m = 16'd0;
               for (int y = 0; y < hdot_pkg::TILE_H; y++) begin
                  for (int x = 0; x < hdot_pkg::TILE_W; x++) begin
                     addr = ((t / hdot_pkg::TILES_X) * hdot_pkg::TILE_H + y) * hdot_pkg::BUF_W
                          + (t % hdot_pkg::TILES_X) * hdot_pkg::TILE_W + x;
                     if (pixel_depth[addr] > m) m = pixel_depth[addr];
                  end
               end
               tile_peak[t] = m;
               if (m != hdot_pkg::DEPTH_EMPTY) buffer_active = 1'b1;
            end
         end
         default: begin
            a.hidden = occlusion_answer(it);
            query_count++;
         end
      endcase
      a.active = buffer_active;
      expected_answers.push_back(a);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) apply_item(held_item);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() > 0 &&
                !(pending_mode[0] == 0 && $urandom_range(99) < 38) &&
                !(pending_mode[0] == 1 && $urandom_range(99) < 77)) begin
               stall_mode = pending_mode.pop_front();
               held_item  = pending_items.pop_front();
               req_tdata  <= {3'b000, held_item};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = expected_answers.pop_front();
               answer_count++;
               if (want.hidden) hidden_count++;
               if (rsp_tdata[0] !== want.hidden) report_mismatch("hidden", rsp_tdata[0], want.hidden);
               if (rsp_tdata[1] !== want.active)
                  report_mismatch("occluders_active", rsp_tdata[1], want.active);
            end
         end
         case (stall_mode)
            0: rsp_tready <= $urandom_range(99) >= 77;
            1: rsp_tready <= $urandom_range(99) >= 38;
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   task automatic push_item(int mode, logic [1:0] act, int px, int py, int d,
                            int x0, int x1, int y0, int y1);
      hdot_pkg::item_type it;
      it.action      = act;
      it.pixel_x     = 8'(px);
      it.pixel_y     = 7'(py);
      it.depth_value = 16'(d);
      it.rect_x0     = 13'(x0);
      it.rect_x1     = 13'(x1);
      it.rect_y0     = 13'(y0);
      it.rect_y1     = 13'(y1);
      pending_items.push_back(it);
      pending_mode.push_back(mode);
   endtask

   task automatic push_query(int mode, int cx, int cy);
      int x0, x1, y0, y1, d, k;
      k  = $urandom_range(99);
      x0 = cx * hdot_pkg::TILE_W + $urandom_range(20) - 6;
      y0 = cy * hdot_pkg::TILE_H + $urandom_range(20) - 6;
      x1 = x0 + $urandom_range(22) - 3;
      y1 = y0 + $urandom_range(22) - 3;
      if (k < 8) begin
         // any coordinates at all
         x0 = $urandom_range(8191) - 4096;
         x1 = $urandom_range(8191) - 4096;
         y0 = $urandom_range(8191) - 4096;
         y1 = $urandom_range(8191) - 4096;
      end else if (k < 13) begin
         // reaching past the buffer edges
         x0 = -int'($urandom_range(4096));
         y0 = -int'($urandom_range(4096));
         x1 = hdot_pkg::BUF_W - 8 + $urandom_range(4103 - hdot_pkg::BUF_W);
         y1 = hdot_pkg::BUF_H - 8 + $urandom_range(4103 - hdot_pkg::BUF_H);
      end else if (k < 16) begin
         x0 = hdot_pkg::BUF_W + $urandom_range(50) - 2;
         x1 = x0 + $urandom_range(9);
      end
      d = ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(65535);
      push_item(mode, hdot_pkg::ACT_QUERY, $urandom_range(255), $urandom_range(127), d,
                x0, x1, y0, y1);
   endtask

   initial begin
      int cx, cy;
      reset = 1'b1;
      rsp_tready  = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      stall_mode  = 2;
      error_count = 0;
      answer_count = 0;
      hidden_count = 0;
      query_count  = 0;
      buffer_active = 1'b0;
      foreach (pixel_depth[i]) pixel_depth[i] = hdot_pkg::DEPTH_EMPTY;
      foreach (tile_peak[i]) tile_peak[i] = 16'd0;

      // directed: inactive query, write extremes, farther write, empty build, clear
      push_item(2, hdot_pkg::ACT_QUERY, 0, 0, 16'hFFFF, 0, 8, 0, 8);
      push_item(2, hdot_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, 0);
      push_item(2, hdot_pkg::ACT_WRITE, 255, 127, 16'hFFFF, -4096, 4095, -4096, 4095);
      push_item(2, hdot_pkg::ACT_WRITE, 0, 0, 16'h8000, 0, 0, 0, 0);
      push_item(2, hdot_pkg::ACT_WRITE, 255, 127, 16'h0001, 0, 0, 0, 0);
      push_item(2, hdot_pkg::ACT_BUILD, 0, 0, 0, 0, 0, 0, 0);
      push_item(2, hdot_pkg::ACT_QUERY, 0, 0, 16'hFFFF, -4096, 4095, -4096, 4095);
      push_item(2, hdot_pkg::ACT_QUERY, 255, 127, 16'hFFFF, 4095, -4096, 4095, -4096);
      push_item(2, hdot_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      push_item(2, hdot_pkg::ACT_QUERY, 0, 0, 0, 0, 1, 0, 1);

      for (int mode = 0; mode < 3; mode++) begin
         cx = $urandom_range(hdot_pkg::TILES_X - 2);
         cy = $urandom_range(hdot_pkg::TILES_Y - 2);
         if (mode == 2) begin
            cx = hdot_pkg::TILES_X - 2;
            cy = hdot_pkg::TILES_Y - 2;
         end
         push_item(mode, hdot_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
         // fill a 2x2 block of tiles completely so that the build sees full tiles
         for (int y = 0; y < 2 * hdot_pkg::TILE_H; y++)
            for (int x = 0; x < 2 * hdot_pkg::TILE_W; x++)
               push_item(mode, hdot_pkg::ACT_WRITE, cx * hdot_pkg::TILE_W + x,
                         cy * hdot_pkg::TILE_H + y, $urandom_range(40000, 1000),
                         0, 0, 0, 0);
         for (int i = 0; i < 15; i++)
            push_item(mode, hdot_pkg::ACT_WRITE, $urandom_range(255), $urandom_range(127),
                      $urandom_range(65535), $urandom_range(8191), $urandom_range(8191),
                      $urandom_range(8191), $urandom_range(8191));
         push_item(mode, hdot_pkg::ACT_BUILD, 0, 0, 0, 0, 0, 0, 0);
         for (int i = 0; i < 90; i++) push_query(mode, cx, cy);
         // revisit the block with nearer and farther depths
         for (int i = 0; i < 60; i++)
            push_item(mode, hdot_pkg::ACT_WRITE, cx * hdot_pkg::TILE_W + $urandom_range(15),
                      cy * hdot_pkg::TILE_H + $urandom_range(15), $urandom_range(65535),
                      0, 0, 0, 0);
         push_item(mode, hdot_pkg::ACT_BUILD, 0, 0, 0, 0, 0, 0, 0);
         for (int i = 0; i < 90; i++) push_query(mode, cx, cy);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0);
      while (expected_answers.size() > 0 || req_tvalid) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d items with %0d queries, %0d of them hidden", answer_count,
               query_count, hidden_count);
      $display("three handshake pressure modes, %0d mismatches", error_count);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d items outstanding", expected_answers.size());
      $display("CHECK FAILED");
      $finish;
   end
endmodule
